// File: rtl/core/tce_pkg.sv
// Shared types, codes and constants for the text console engine.
// No dependencies; every other file except tce_ram uses these by scoped name.
package tce_pkg;

    // Default geometry
    localparam int COLS_DEF = 80;
    localparam int ROWS_DEF = 25;
    localparam int TAB_DEF  = 8;

    // Stream word widths
    localparam int IN_W  = 24;
    localparam int OUT_W = 40;

    // Command codes
    localparam logic [1:0] CMD_PUT  = 2'd0;
    localparam logic [1:0] CMD_SET  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // Control characters and printable range
    localparam logic [7:0] CHAR_BS  = 8'h08;
    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_FF  = 8'h0C;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] PRINT_LO = 8'h20;
    localparam logic [7:0] PRINT_HI = 8'h7E;

    localparam logic [7:0] DEFAULT_COLOR_RST = 8'h07;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

    typedef enum logic {
        SW_IDLE,
        SW_RUN
    } t_sweep_state;

    // Request to rewrite the whole cell store
    typedef struct packed {
        logic       start;
        logic       copy;   // shift rows up before filling the last one
        logic [7:0] fill;
    } t_sweep_cmd;

    // Fill byte: high nibble of the color in both nibbles
    function automatic logic [7:0] fill_byte(input logic [7:0] color);
        return {color[7:4], color[7:4]};
    endfunction

endpackage

// File: rtl/core/tce_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/tce_cursor.sv
// Cursor, current color and put-character decode of the text console.
// Depends on tce_pkg; drives single cell writes and sweep requests.
module tce_cursor #(
    parameter int COLS = tce_pkg::COLS_DEF,
    parameter int ROWS = tce_pkg::ROWS_DEF,
    parameter int TAB  = tce_pkg::TAB_DEF,
    parameter int AW   = $clog2(COLS * ROWS)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_put,
    input  logic                      i_set,
    input  logic [7:0]                i_value,
    input  logic [7:0]                i_default_color,
    output logic [$clog2(COLS)-1:0]   o_col,
    output logic [$clog2(ROWS)-1:0]   o_row,
    output logic                      o_cell_we,
    output logic [AW-1:0]             o_cell_addr,
    output logic [15:0]               o_cell_wdata,
    output tce_pkg::t_sweep_cmd       o_sweep
);

    localparam int CW  = $clog2(COLS);
    localparam int CXW = $clog2(COLS + TAB + 1);
    localparam int RW  = $clog2(ROWS);
    localparam int RXW = $clog2(ROWS + 1);
    localparam int TW  = (TAB > 1) ? $clog2(TAB) : 1;

    logic [CW-1:0] r_col,   n_col;
    logic [RW-1:0] r_row,   n_row;
    logic [AW-1:0] r_base,  n_base;   // row times COLS
    logic [TW-1:0] r_tab,   n_tab;    // column modulo TAB
    logic [7:0]    r_color, n_color;

    logic [CXW-1:0] col_x;
    logic [RXW-1:0] row_x;
    logic [TW-1:0]  tab_x;
    logic           lf, ff, prn, wrap, scroll;

    always_comb begin
        col_x = CXW'(r_col);
        tab_x = r_tab;
        lf    = 1'b0;
        ff    = 1'b0;
        prn   = 1'b0;
        if (i_put) begin
            unique case (i_value)
                tce_pkg::CHAR_BS: begin
                    if (r_col != '0) begin
                        col_x = CXW'(r_col) - CXW'(1);
                        tab_x = (r_tab == '0) ? TW'(TAB - 1) : r_tab - TW'(1);
                    end
                end
                tce_pkg::CHAR_CR: begin
                    col_x = '0;
                    tab_x = '0;
                end
                tce_pkg::CHAR_LF: begin
                    lf    = 1'b1;
                    col_x = '0;
                    tab_x = '0;
                end
                tce_pkg::CHAR_FF: begin
                    ff    = 1'b1;
                    col_x = '0;
                    tab_x = '0;
                end
                tce_pkg::CHAR_TAB: begin
                    col_x = CXW'(r_col) + CXW'(TAB) - CXW'(r_tab);
                    tab_x = '0;
                end
                default: begin
                    if (i_value >= tce_pkg::PRINT_LO && i_value <= tce_pkg::PRINT_HI) begin
                        prn   = 1'b1;
                        col_x = CXW'(r_col) + CXW'(1);
                        tab_x = (r_tab == TW'(TAB - 1)) ? '0 : r_tab + TW'(1);
                    end
                end
            endcase
        end

        // Wrap at the right edge
        wrap = (col_x >= CXW'(COLS));
        if (wrap) begin
            col_x = '0;
            tab_x = '0;
        end

        row_x  = RXW'(r_row) + RXW'(lf | wrap);
        scroll = (row_x == RXW'(ROWS));

        n_col = col_x[CW-1:0];
        n_tab = tab_x;
        if (ff) begin
            n_row = '0;
        end else if (scroll) begin
            n_row = RW'(ROWS - 1);
        end else begin
            n_row = row_x[RW-1:0];
        end

        n_base = r_base;
        if (ff) begin
            n_base = '0;
        end else if ((lf | wrap) && !scroll) begin
            n_base = r_base + AW'(COLS);
        end

        n_color = r_color;
        if (ff) begin
            n_color = i_default_color;
        end else if (i_set) begin
            n_color = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_base  <= '0;
            r_tab   <= '0;
            r_color <= tce_pkg::DEFAULT_COLOR_RST;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_base  <= n_base;
            r_tab   <= n_tab;
            r_color <= n_color;
        end
    end

    assign o_col        = n_col;
    assign o_row        = n_row;
    assign o_cell_we    = prn;
    assign o_cell_addr  = r_base + AW'(r_col);
    assign o_cell_wdata = {r_color, i_value};

    always_comb begin
        o_sweep.start = ff | scroll;
        o_sweep.copy  = !ff;
        o_sweep.fill  = ff ? tce_pkg::fill_byte(i_default_color)
                           : tce_pkg::fill_byte(r_color);
    end

endmodule

// File: rtl/core/tce_sweep.sv
// Whole-store sweep: clear to a fill byte, or scroll up one row and fill.
// Depends on tce_pkg; drives the cell RAM ports while it runs.
module tce_sweep #(
    parameter int COLS   = tce_pkg::COLS_DEF,
    parameter int NCELLS = tce_pkg::COLS_DEF * tce_pkg::ROWS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tce_pkg::t_sweep_cmd       i_cmd,
    input  logic [15:0]               i_rdata,
    output logic                      o_busy,
    output logic                      o_we,
    output logic [$clog2(NCELLS)-1:0] o_waddr,
    output logic [15:0]               o_wdata,
    output logic                      o_re,
    output logic [$clog2(NCELLS)-1:0] o_raddr
);

    localparam int AW = $clog2(NCELLS);

    tce_pkg::t_sweep_state r_state, n_state;
    logic [AW-1:0]         r_ptr;
    logic                  r_copy;
    logic [7:0]            r_fill;
    logic [AW:0]           rd_next;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tce_pkg::SW_IDLE: if (i_cmd.start) n_state = tce_pkg::SW_RUN;
            tce_pkg::SW_RUN:  if (r_ptr == AW'(NCELLS - 1)) n_state = tce_pkg::SW_IDLE;
            default:          n_state = tce_pkg::SW_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tce_pkg::SW_RUN;
            r_ptr   <= '0;
            r_copy  <= 1'b0;
            r_fill  <= tce_pkg::fill_byte(tce_pkg::DEFAULT_COLOR_RST);
        end else begin
            r_state <= n_state;
            if (r_state == tce_pkg::SW_IDLE) begin
                if (i_cmd.start) begin
                    r_ptr  <= '0;
                    r_copy <= i_cmd.copy;
                    r_fill <= i_cmd.fill;
                end
            end else begin
                r_ptr <= r_ptr + AW'(1);
            end
        end
    end

    // Outputs: read one row ahead, write the current cell
    always_comb begin
        rd_next = (AW+1)'(r_ptr) + (AW+1)'(COLS + 1);
        o_busy  = (r_state == tce_pkg::SW_RUN);
        o_we    = o_busy;
        o_waddr = r_ptr;
        o_wdata = (r_copy && r_ptr < AW'(NCELLS - COLS)) ? i_rdata : {r_fill, r_fill};
        o_re    = 1'b0;
        o_raddr = rd_next[AW-1:0];
        unique case (r_state)
            tce_pkg::SW_IDLE: begin
                if (i_cmd.start && i_cmd.copy) begin
                    o_re    = 1'b1;
                    o_raddr = AW'(COLS);
                end
            end
            tce_pkg::SW_RUN: begin
                o_re = r_copy && (rd_next < (AW+1)'(NCELLS));
            end
            default: o_re = 1'b0;
        endcase
    end

endmodule

// File: rtl/core/text_console_engine.sv
// Text console engine: a COLS x ROWS store of character/attribute cells driven
// by put-character, set-color and read-cell words. A put, set-color or unused
// command loads its result word when taken; a cell read holds input off while the
// cell RAM's registered read data comes back. A form feed, or a put that scrolls
// past the last row, occupies the RAM's single write port while every cell is
// rewritten; input stays stalled for that time. After reset a clearing pass fills
// the store before the first word is taken; the configuration register may be
// written during it.
module text_console_engine #(
    parameter int COLS = tce_pkg::COLS_DEF,
    parameter int ROWS = tce_pkg::ROWS_DEF,
    parameter int TAB  = tce_pkg::TAB_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [7:0]               i_cfg_wr_data,   // default_color
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [1:0]               s_axis_tuser,    // cmd[1:0]
    input  logic [tce_pkg::IN_W-1:0] s_axis_tdata,    // value[7:0] cell_index[18:8]
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic                     m_axis_tuser,    // echo_valid[0]
    // cursor_col[6:0] cursor_row[11:7] echo_char[19:12]
    // cell_char[27:20] cell_attr[35:28]
    output logic [tce_pkg::OUT_W-1:0] m_axis_tdata
);

    localparam int NCELLS = COLS * ROWS;
    localparam int AW     = $clog2(NCELLS);
    localparam int CW     = $clog2(COLS);
    localparam int RW     = $clog2(ROWS);

    logic [1:0]  in_cmd;
    logic [7:0]  in_value;
    logic [10:0] in_idx;
    logic        acc, put, set, rd, rd_ok;

    tce_pkg::t_state r_state, n_state;
    logic            r_rd_ok;
    logic [7:0]      r_default_color;
    logic            r_out_valid;
    logic            r_out_user;
    logic [tce_pkg::OUT_W-1:0] r_out_data;

    logic [CW-1:0]  cur_col;
    logic [RW-1:0]  cur_row;
    logic           cur_we;
    logic [AW-1:0]  cur_addr;
    logic [15:0]    cur_wdata;
    tce_pkg::t_sweep_cmd sweep_cmd;

    logic           sw_busy, sw_we, sw_re;
    logic [AW-1:0]  sw_waddr, sw_raddr;
    logic [15:0]    sw_wdata;

    logic           ram_we, ram_re;
    logic [AW-1:0]  ram_waddr, ram_raddr;
    logic [15:0]    ram_wdata, ram_rdata;

    logic [31:0]    col_w, row_w;
    logic           load_now, load_rd;
    logic [7:0]     res_echo, res_char, res_attr;

    assign in_cmd   = s_axis_tuser;
    assign in_value = s_axis_tdata[7:0];
    assign in_idx   = s_axis_tdata[18:8];

    assign s_axis_tready = (r_state == tce_pkg::ST_IDLE) && !sw_busy
                         && (!r_out_valid || m_axis_tready);
    assign acc   = s_axis_tvalid && s_axis_tready;
    assign put   = acc && (in_cmd == tce_pkg::CMD_PUT);
    assign set   = acc && (in_cmd == tce_pkg::CMD_SET);
    assign rd    = acc && (in_cmd == tce_pkg::CMD_READ);
    assign rd_ok = (32'(in_idx) < 32'(NCELLS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_color <= tce_pkg::DEFAULT_COLOR_RST;
        end else if (i_cfg_wr_en) begin
            r_default_color <= i_cfg_wr_data;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tce_pkg::ST_IDLE: if (rd) n_state = tce_pkg::ST_READ;
            tce_pkg::ST_READ: n_state = tce_pkg::ST_IDLE;
            default:          n_state = tce_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tce_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd) begin
            r_rd_ok <= rd_ok;
        end
    end

    tce_cursor #(
        .COLS (COLS),
        .ROWS (ROWS),
        .TAB  (TAB),
        .AW   (AW)
    ) u_cursor (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_put           (put),
        .i_set           (set),
        .i_value         (in_value),
        .i_default_color (r_default_color),
        .o_col           (cur_col),
        .o_row           (cur_row),
        .o_cell_we       (cur_we),
        .o_cell_addr     (cur_addr),
        .o_cell_wdata    (cur_wdata),
        .o_sweep         (sweep_cmd)
    );

    tce_sweep #(
        .COLS   (COLS),
        .NCELLS (NCELLS)
    ) u_sweep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (sweep_cmd),
        .i_rdata (ram_rdata),
        .o_busy  (sw_busy),
        .o_we    (sw_we),
        .o_waddr (sw_waddr),
        .o_wdata (sw_wdata),
        .o_re    (sw_re),
        .o_raddr (sw_raddr)
    );

    // Sweep owns the ports while it runs; items only get them when it is idle
    assign ram_we    = sw_we | cur_we;
    assign ram_waddr = sw_we ? sw_waddr : cur_addr;
    assign ram_wdata = sw_we ? sw_wdata : cur_wdata;
    assign ram_re    = sw_re | (rd && rd_ok);
    assign ram_raddr = sw_re ? sw_raddr : AW'(in_idx);

    tce_ram #(
        .WIDTH (16),
        .DEPTH (NCELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Result word: loaded at accept, or in the cycle after for a cell read
    assign col_w    = 32'(cur_col);
    assign row_w    = 32'(cur_row);
    assign load_now = acc && (in_cmd != tce_pkg::CMD_READ);
    assign load_rd  = (r_state == tce_pkg::ST_READ);
    assign res_echo = put ? in_value : 8'h00;
    assign res_char = (load_rd && r_rd_ok) ? ram_rdata[7:0]  : 8'h00;
    assign res_attr = (load_rd && r_rd_ok) ? ram_rdata[15:8] : 8'h00;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_now || load_rd) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_now || load_rd) begin
            r_out_user <= put;
            r_out_data <= {(tce_pkg::OUT_W - 36)'(0), res_attr, res_char, res_echo,
                           row_w[4:0], col_w[6:0]};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tdata  = r_out_data;

endmodule

// File: rtl/core/tce_chk.sv
// Port-level checks for the text console engine, bound to its top level.
// Depends on tce_pkg and text_console_engine.
module tce_chk #(
    parameter int COLS = tce_pkg::COLS_DEF
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_cfg_wr_en,
    input logic [7:0]                i_cfg_wr_data,
    input logic                      s_axis_tvalid,
    input logic                      s_axis_tready,
    input logic [1:0]                s_axis_tuser,
    input logic [tce_pkg::IN_W-1:0]  s_axis_tdata,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic                      m_axis_tuser,
    input logic [tce_pkg::OUT_W-1:0] m_axis_tdata
);

    // Take input only when the result slot is free or draining
    a_ready_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (!m_axis_tvalid || m_axis_tready))
        else $error("input taken with result slot blocked");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("stalled result word changed");

    a_fast_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser != tce_pkg::CMD_READ
        |=> m_axis_tvalid)
        else $error("missing result for put or set word");

    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == tce_pkg::CMD_READ
        |=> !s_axis_tready ##1 m_axis_tvalid)
        else $error("cell read result late or input not held");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (32'(m_axis_tdata[6:0]) < 32'(COLS)))
        else $error("cursor column out of range");

endmodule

bind text_console_engine tce_chk #(.COLS(COLS)) u_tce_chk (.*);
